>>> rtl/othr_pkg.sv
// ----------------------------------------------------------------------------
// othr_pkg
// Shared widths, types and codes of the Otsu threshold block.
// ----------------------------------------------------------------------------
package othr_pkg;

  localparam int unsigned NBINS       = 256;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CNT_W       = 25;
  localparam int unsigned T_W         = 32;
  localparam int unsigned D_W         = CNT_W + T_W;
  localparam int unsigned DEN_W       = 2 * CNT_W;
  localparam int unsigned A_W         = 2 * D_W;
  localparam int unsigned B_W         = D_W;
  localparam int unsigned P_W         = A_W + B_W;
  localparam int unsigned MAX_PIXELS_DEF = 1048576;

  typedef enum logic [1:0] {
    MSEL_SQ  = 2'd0,
    MSEL_LHS = 2'd1,
    MSEL_RHS = 2'd2
  } msel_e;

  typedef struct packed {
    logic  intake_en;
    logic  scan_init;
    logic  zero_we;
    logic  idx_inc;
    logic  acc;
    logic  calc;
    logic  diff;
    logic  mul_start;
    msel_e msel;
    logic  mul_cap;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic skip;
    logic idx_last;
    logic last_acc;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/othr_if.sv
// ----------------------------------------------------------------------------
// othr_in_if / othr_out_if
// Valid/ready channels for pixel beats and threshold beats.
// ----------------------------------------------------------------------------
interface othr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;
  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface othr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] threshold;
  modport source (output valid, output threshold, input ready);
  modport sink   (input valid, input threshold, output ready);
endinterface

>>> rtl/othr_mul.sv
// ----------------------------------------------------------------------------
// othr_mul
// Iterative shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module othr_mul
  import othr_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic           busy_o,
  output logic [P_W-1:0] p_o
);

  logic [P_W-1:0] a_q;
  logic [B_W-1:0] b_q;
  logic [P_W-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (start_i) begin
      b_q <= b_i;
    end else if (b_q != '0) begin
      b_q <= b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= P_W'(a_i);
      p_q <= '0;
    end else if (b_q != '0) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
    end
  end

  assign busy_o = (b_q != '0);
  assign p_o    = p_q;

endmodule

>>> rtl/othr_dp.sv
// ----------------------------------------------------------------------------
// othr_dp
// Histogram memory, frame accumulators and between-class variance datapath.
// ----------------------------------------------------------------------------
module othr_dp
  import othr_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             in_valid_i,
  input  logic [PIX_W-1:0] in_pixel_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [PIX_W-1:0] out_threshold_o
);

  logic [CNT_W-1:0] mem_q [NBINS];
  logic [CNT_W-1:0] rd_q;
  logic [PIX_W-1:0] rd_addr;
  logic             we;
  logic [PIX_W-1:0] wa;
  logic [CNT_W-1:0] wd;

  logic             in_acc;
  logic             cnt_ok;
  logic             s1_valid_q;
  logic [PIX_W-1:0] pix1_q;
  logic             fwd_q;
  logic [CNT_W-1:0] fwd_val_q;
  logic [CNT_W-1:0] cnt1;

  logic [CNT_W-1:0] n_q;
  logic [T_W-1:0]   t_q;
  logic [PIX_W-1:0] idx_q;
  logic [CNT_W-1:0] w_q;
  logic [T_W-1:0]   s_q;
  logic [D_W-1:0]   a_q;
  logic [D_W-1:0]   b_q;
  logic [D_W-1:0]   d_q;
  logic [DEN_W-1:0] den_q;
  logic [A_W-1:0]   num_q;
  logic [P_W-1:0]   lhs_q;
  logic [A_W-1:0]   best_num_q;
  logic [DEN_W-1:0] best_den_q;
  logic [PIX_W-1:0] thr_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_thr_q;

  logic [A_W-1:0]   mul_a;
  logic [B_W-1:0]   mul_b;
  logic             mul_busy;
  logic [P_W-1:0]   mul_p;

  assign in_acc  = in_valid_i & cmd_i.intake_en;
  assign cnt_ok  = (n_q < CNT_W'(MAX_PIXELS));
  assign cnt1    = fwd_q ? fwd_val_q : rd_q;
  assign rd_addr = cmd_i.intake_en ? in_pixel_i : idx_q;
  assign we      = s1_valid_q | cmd_i.zero_we;
  assign wa      = s1_valid_q ? pix1_q : idx_q;
  assign wd      = s1_valid_q ? cnt1 + CNT_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // pixel intake, read-modify-write with forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      n_q        <= '0;
      t_q        <= '0;
      idx_q      <= '0;
    end else begin
      s1_valid_q <= in_acc & cnt_ok;
      if (in_acc && cnt_ok) begin
        fwd_q <= s1_valid_q && (pix1_q == in_pixel_i);
        n_q   <= n_q + CNT_W'(1);
        t_q   <= t_q + T_W'(in_pixel_i);
      end
      if (cmd_i.out_load) begin
        n_q <= '0;
        t_q <= '0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_ok) begin
      pix1_q    <= in_pixel_i;
      fwd_val_q <= cnt1 + CNT_W'(1);
    end
  end

  // scan arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      w_q        <= '0;
      s_q        <= '0;
      best_num_q <= '0;
      best_den_q <= DEN_W'(1);
      thr_q      <= '0;
    end
    if (cmd_i.acc) begin
      w_q <= w_q + rd_q;
      s_q <= s_q + T_W'(idx_q * rd_q);
    end
    if (cmd_i.calc) begin
      a_q   <= D_W'(t_q) * D_W'(w_q);
      b_q   <= D_W'(s_q) * D_W'(n_q);
      den_q <= DEN_W'(w_q) * DEN_W'(n_q - w_q);
    end
    if (cmd_i.diff) begin
      d_q <= (a_q > b_q) ? a_q - b_q : b_q - a_q;
    end
    if (cmd_i.mul_cap) begin
      case (cmd_i.msel)
        MSEL_SQ:  num_q <= mul_p[A_W-1:0];
        MSEL_LHS: lhs_q <= mul_p;
        MSEL_RHS: begin
          if (lhs_q > mul_p) begin
            best_num_q <= num_q;
            best_den_q <= den_q;
            thr_q      <= idx_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.msel)
      MSEL_SQ: begin
        mul_a = A_W'(d_q);
        mul_b = d_q;
      end
      MSEL_LHS: begin
        mul_a = num_q;
        mul_b = B_W'(best_den_q);
      end
      MSEL_RHS: begin
        mul_a = best_num_q;
        mul_b = B_W'(den_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  othr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .p_o     (mul_p)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_thr_q <= thr_q;
    end
  end

  assign sts_o.mul_busy = mul_busy;
  assign sts_o.skip     = (w_q == '0) || (w_q >= n_q);
  assign sts_o.idx_last = (idx_q == PIX_W'(NBINS - 1));
  assign sts_o.last_acc = in_acc & in_last_i;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_threshold_o = out_thr_q;

endmodule

>>> rtl/othr_ctrl.sv
// ----------------------------------------------------------------------------
// othr_ctrl
// Sequencer for reset clearing, pixel intake and the per-frame bin scan.
// ----------------------------------------------------------------------------
module othr_ctrl
  import othr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_RUN   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_CALC  = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_SQW   = 4'd8;
  localparam logic [3:0] S_LHS   = 4'd9;
  localparam logic [3:0] S_LHSW  = 4'd10;
  localparam logic [3:0] S_RHS   = 4'd11;
  localparam logic [3:0] S_RHSW  = 4'd12;
  localparam logic [3:0] S_NEXT  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.msel = MSEL_SQ;
    case (state_q)
      S_CLR: begin
        cmd_o.zero_we = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.intake_en = 1'b1;
        if (sts_i.last_acc) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.scan_init = 1'b1;
        state_d = S_RD;
      end
      S_RD: state_d = S_ACC;
      S_ACC: begin
        cmd_o.acc     = 1'b1;
        cmd_o.zero_we = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = sts_i.skip ? S_NEXT : S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_SQW;
      end
      S_SQW: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_cap = 1'b1;
          state_d = S_LHS;
        end
      end
      S_LHS: begin
        cmd_o.msel      = MSEL_LHS;
        cmd_o.mul_start = 1'b1;
        state_d = S_LHSW;
      end
      S_LHSW: begin
        cmd_o.msel = MSEL_LHS;
        if (!sts_i.mul_busy) begin
          cmd_o.mul_cap = 1'b1;
          state_d = S_RHS;
        end
      end
      S_RHS: begin
        cmd_o.msel      = MSEL_RHS;
        cmd_o.mul_start = 1'b1;
        state_d = S_RHSW;
      end
      S_RHSW: begin
        cmd_o.msel = MSEL_RHS;
        if (!sts_i.mul_busy) begin
          cmd_o.mul_cap = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.idx_inc = 1'b1;
        state_d = sts_i.idx_last ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_RUN;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

endmodule

>>> rtl/otsu_threshold_histogram.sv
// ----------------------------------------------------------------------------
// otsu_threshold_histogram
// Otsu threshold of a frame of 8-bit gray pixels from a 256-bin histogram.
// ----------------------------------------------------------------------------
// Pixels are taken one beat per cycle and counted into a 256-entry histogram
// memory through a read-modify-write stage with forwarding. The beat marked
// last ends the frame: input stalls while the bins are scanned one at a time,
// each bin taking a read, accumulate, calculate and next step, plus a
// difference step and 3 shift-add multiplications (one multiplier bit per
// cycle between start and capture) when its cumulative weight lies strictly
// between 0 and the frame size, so a frame end holds the input until the scan
// is done, plus any wait for the previous threshold beat to be taken; the scan
// clears the bins as it reads them. Pixels past MAX_PIXELS in one frame are
// dropped. After reset the histogram is cleared in a pass over all 256 bins
// before the first pixel beat.
// ----------------------------------------------------------------------------
module otsu_threshold_histogram
  import othr_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  othr_in_if.sink    pix_i,
  othr_out_if.source thr_o
);

  cmd_t cmd;
  sts_t sts;

  othr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  othr_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (pix_i.valid),
    .in_pixel_i      (pix_i.pixel),
    .in_last_i       (pix_i.last_pixel),
    .out_ready_i     (thr_o.ready),
    .out_valid_o     (thr_o.valid),
    .out_threshold_o (thr_o.threshold)
  );

  assign pix_i.ready = cmd.intake_en;

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready && pix_i.last_pixel) |=> !pix_i.ready)
    else $error("intake not stalled after last pixel");

  a_mul_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier restarted while busy");

  a_clear_no_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.zero_we |-> !pix_i.ready)
    else $error("bin clear overlaps pixel intake");

endmodule
